/* design/graph_bfs_order_top_assert.svh */
// ----------------------------------------------------------------------------
// graph_bfs_order_top_assert.svh - assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_ORDER_TOP_ASSERT_SVH
`define GRAPH_BFS_ORDER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define GBFS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("gbfs assertion failed");
`define GBFS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("gbfs assertion failed");
`else
`define GBFS_ASSERT(lbl, prop)
`define GBFS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/gbfs_pkg.sv */
// ----------------------------------------------------------------------------
// gbfs_pkg - shared types and constants
// Item formats, command format, mode and status codes.
// ----------------------------------------------------------------------------
package gbfs_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int VW  = 6;
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = EAW + 1;
    localparam int QAW = $clog2(MAX_VERTICES);

    localparam logic [VCW-1:0] VCNT_MAX = VCW'(MAX_VERTICES);
    localparam logic [ECW-1:0] ECNT_MAX = ECW'(MAX_EDGES);

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_ALL    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]    mode;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
    } t_in;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic          last;
        logic [1:0]    status;
    } t_out;

    typedef struct packed {
        logic [1:0]     mode;
        logic [VW-1:0]  a;
        logic [VW-1:0]  b;
        logic [VCW-1:0] lim;
        logic           oor;
    } t_cmd;
endpackage

/* design/gbfs_front.sv */
// ----------------------------------------------------------------------------
// gbfs_front - input side
// Holds vertex_count, range-checks items and queues commands for the back.
// ----------------------------------------------------------------------------
module gbfs_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gbfs_pkg::VCW-1:0]         i_cfg_wdata,
    input  logic                             push,
    output logic                             full,
    input  gbfs_pkg::t_in                    i_item,
    output logic                             o_cmd_valid,
    output gbfs_pkg::t_cmd                   o_cmd,
    input  logic                             i_cmd_take
);
    logic [gbfs_pkg::VCW-1:0] r_vcount;
    gbfs_pkg::t_cmd           r_q [2];
    logic                     r_wp, r_rp;
    logic [1:0]               r_cnt;
    logic [gbfs_pkg::VCW-1:0] lim;
    gbfs_pkg::t_cmd           cmd;
    logic                     acc, take;

    always_comb begin
        lim      = (r_vcount < gbfs_pkg::VCNT_MAX) ? r_vcount : gbfs_pkg::VCNT_MAX;
        cmd.mode = i_item.mode;
        cmd.a    = i_item.vertex_a;
        cmd.b    = i_item.vertex_b;
        cmd.lim  = lim;
        case (i_item.mode)
            gbfs_pkg::MODE_ADD:
                cmd.oor = ({1'b0, i_item.vertex_a} >= lim) || ({1'b0, i_item.vertex_b} >= lim);
            gbfs_pkg::MODE_SEARCH: cmd.oor = ({1'b0, i_item.vertex_a} >= lim);
            default:               cmd.oor = 1'b0;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign acc         = push && !full;
    assign take        = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= gbfs_pkg::VCNT_MAX;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_cfg_we) r_vcount <= i_cfg_wdata;
            if (acc)  r_wp <= ~r_wp;
            if (take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_q[r_wp] <= cmd;
    end
endmodule

/* design/gbfs_res_fifo.sv */
// ----------------------------------------------------------------------------
// gbfs_res_fifo - result queue
// Four-entry queue between the search engine and the result port.
// ----------------------------------------------------------------------------
module gbfs_res_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gbfs_pkg::t_out i_res,
    output logic           o_full,
    output logic           empty,
    input  logic           pop,
    output gbfs_pkg::t_out o_res
);
    gbfs_pkg::t_out r_mem [4];
    logic [1:0]     r_wp, r_rp;
    logic [2:0]     r_cnt;
    logic           wr, rd;

    assign o_full = (r_cnt == 3'd4);
    assign empty  = (r_cnt == 3'd0);
    assign o_res  = r_mem[r_rp];
    assign wr     = i_push && !o_full;
    assign rd     = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, wr} - {2'd0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_res;
    end
endmodule

/* design/gbfs_back.sv */
// ----------------------------------------------------------------------------
// gbfs_back - search engine
// Edge store, visited map, vertex queue and the BFS sequencer.
// ----------------------------------------------------------------------------
module gbfs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  gbfs_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    output logic           o_res_push,
    output gbfs_pkg::t_out o_res,
    input  logic           i_res_full
);
`include "graph_bfs_order_top_assert.svh"
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEQ  = 3'd1;
    localparam logic [2:0] S_POPW = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_NEXT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]                         r_state, n_state;
    logic [gbfs_pkg::ECW-1:0]           r_ecount, n_ecount;
    logic [1:0]                         r_mode, n_mode;
    logic [gbfs_pkg::VCW-1:0]           r_lim, n_lim;
    logic [gbfs_pkg::MAX_VERTICES-1:0]  r_vis, n_vis;
    logic [gbfs_pkg::VCW-1:0]           r_head, n_head, r_tail, n_tail, r_s, n_s;
    logic [gbfs_pkg::ECW-1:0]           r_eaddr, n_eaddr;
    logic                               r_dv, n_dv;
    logic [gbfs_pkg::VW-1:0]            r_pend_v, n_pend_v;
    logic                               r_pend_vld, n_pend_vld;

    logic [2*gbfs_pkg::VW-1:0] r_emem [gbfs_pkg::MAX_EDGES];
    logic [2*gbfs_pkg::VW-1:0] r_edata;
    logic [gbfs_pkg::VW-1:0]   r_qmem [gbfs_pkg::MAX_VERTICES];
    logic [gbfs_pkg::VW-1:0]   r_qdata;

    logic                      e_we, e_re, q_we, q_re;
    logic [gbfs_pkg::EAW-1:0]  e_waddr, e_raddr;
    logic [2*gbfs_pkg::VW-1:0] e_wdata;
    logic [gbfs_pkg::QAW-1:0]  q_waddr, q_raddr;
    logic [gbfs_pkg::VW-1:0]   q_wdata;

    logic [gbfs_pkg::VW-1:0] ef, es, other;
    logic                    hit;

    always_comb begin
        n_state = r_state;   n_ecount = r_ecount; n_mode = r_mode; n_lim = r_lim;
        n_vis = r_vis;       n_head = r_head;     n_tail = r_tail; n_s = r_s;
        n_eaddr = r_eaddr;   n_dv = r_dv;         n_pend_v = r_pend_v;
        n_pend_vld = r_pend_vld;
        e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_re = 1'b0; e_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;
        o_cmd_take = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        ef = r_edata[2*gbfs_pkg::VW-1:gbfs_pkg::VW];
        es = r_edata[gbfs_pkg::VW-1:0];
        hit = 1'b0;
        other = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_take = 1'b1;
                    n_mode     = i_cmd.mode;
                    n_lim      = i_cmd.lim;
                    o_res.last = 1'b1;
                    case (i_cmd.mode)
                        gbfs_pkg::MODE_CLEAR: begin
                            n_ecount   = '0;
                            o_res_push = 1'b1;
                        end
                        gbfs_pkg::MODE_ADD: begin
                            o_res_push = 1'b1;
                            if (i_cmd.oor) begin
                                o_res.status = gbfs_pkg::ST_RANGE;
                            end else if (r_ecount >= gbfs_pkg::ECNT_MAX) begin
                                o_res.status = gbfs_pkg::ST_FULL;
                            end else begin
                                e_we     = 1'b1;
                                e_waddr  = r_ecount[gbfs_pkg::EAW-1:0];
                                e_wdata  = {i_cmd.a, i_cmd.b};
                                n_ecount = r_ecount + gbfs_pkg::ECW'(1);
                            end
                        end
                        gbfs_pkg::MODE_SEARCH: begin
                            if (i_cmd.oor) begin
                                o_res_push   = 1'b1;
                                o_res.status = gbfs_pkg::ST_RANGE;
                            end else begin
                                n_vis           = '0;
                                n_vis[i_cmd.a]  = 1'b1;
                                q_we            = 1'b1;
                                q_wdata         = i_cmd.a;
                                n_head          = '0;
                                n_tail          = gbfs_pkg::VCW'(1);
                                n_pend_vld      = 1'b0;
                                n_state         = S_DEQ;
                            end
                        end
                        default: begin
                            n_vis      = '0;
                            n_pend_vld = 1'b0;
                            n_s        = '0;
                            n_state    = S_NEXT;
                        end
                    endcase
                end
            end
            S_NEXT: begin
                if (r_s >= r_lim) begin
                    n_state = S_FIN;
                end else begin
                    n_s = r_s + gbfs_pkg::VCW'(1);
                    if (!r_vis[r_s[gbfs_pkg::VW-1:0]]) begin
                        n_vis[r_s[gbfs_pkg::VW-1:0]] = 1'b1;
                        q_we    = 1'b1;
                        q_wdata = r_s[gbfs_pkg::VW-1:0];
                        n_head  = '0;
                        n_tail  = gbfs_pkg::VCW'(1);
                        n_state = S_DEQ;
                    end
                end
            end
            S_DEQ: begin
                if (r_head < r_tail) begin
                    q_re    = 1'b1;
                    q_raddr = r_head[gbfs_pkg::QAW-1:0];
                    n_head  = r_head + gbfs_pkg::VCW'(1);
                    n_state = S_POPW;
                end else begin
                    n_state = (r_mode == gbfs_pkg::MODE_ALL) ? S_NEXT : S_FIN;
                end
            end
            S_POPW: begin
                if (!(r_pend_vld && i_res_full)) begin
                    o_res_push   = r_pend_vld;
                    o_res.vertex = r_pend_v;
                    n_pend_v     = r_qdata;
                    n_pend_vld   = 1'b1;
                    n_eaddr      = '0;
                    n_dv         = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                // check the edge read last cycle against the current vertex
                if (r_dv) begin
                    if (ef == r_pend_v) begin
                        hit = 1'b1; other = es;
                    end else if (es == r_pend_v) begin
                        hit = 1'b1; other = ef;
                    end
                    if (hit && ({1'b0, other} < r_lim) && !r_vis[other]
                        && (r_tail < gbfs_pkg::VCNT_MAX)) begin
                        n_vis[other] = 1'b1;
                        q_we    = 1'b1;
                        q_waddr = r_tail[gbfs_pkg::QAW-1:0];
                        q_wdata = other;
                        n_tail  = r_tail + gbfs_pkg::VCW'(1);
                    end
                end
                if (r_eaddr < r_ecount) begin
                    e_re    = 1'b1;
                    e_raddr = r_eaddr[gbfs_pkg::EAW-1:0];
                    n_eaddr = r_eaddr + gbfs_pkg::ECW'(1);
                    n_dv    = 1'b1;
                end else begin
                    n_dv    = 1'b0;
                    n_state = S_DEQ;
                end
            end
            S_FIN: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    o_res.vertex = r_pend_v;
                    o_res.last   = 1'b1;
                    n_pend_vld   = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ecount   <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_dv       <= 1'b0;
            r_pend_vld <= 1'b0;
            r_vis      <= '0;
        end else begin
            r_state    <= n_state;
            r_ecount   <= n_ecount;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_dv       <= n_dv;
            r_pend_vld <= n_pend_vld;
            r_vis      <= n_vis;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_lim    <= n_lim;
        r_s      <= n_s;
        r_eaddr  <= n_eaddr;
        r_pend_v <= n_pend_v;
    end

    always_ff @(posedge i_clk) begin
        if (e_we) r_emem[e_waddr] <= e_wdata;
        if (e_re) r_edata <= r_emem[e_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) r_qmem[q_waddr] <= q_wdata;
        if (q_re) r_qdata <= r_qmem[q_raddr];
    end

    `GBFS_ASSERT(a_head_le_tail, r_head <= r_tail)
    `GBFS_ASSERT(a_push_has_room, !o_res_push || !i_res_full)
    `GBFS_ASSERT_NEXT(a_idle_after_fin, (r_state == S_FIN) && !r_pend_vld, r_state == S_IDLE)
endmodule

/* design/graph_bfs_order_top.sv */
// ----------------------------------------------------------------------------
// graph_bfs_order_top - breadth-first search engine
// Stores undirected edges and streams BFS visit orders.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      i_item  (mode, vertex_a, vertex_b)
//  result    empty / pop      o_res   (vertex, last, status)
//  config    i_cfg_we         i_cfg_wdata (vertex_count)
//
//  Clear and add-edge items are each handled in the engine's idle state, so
//  edge loads stream at one per cycle while the result queue has room; each
//  result reaches the result ports through the command and result queues.
//  A search scans the edge store once per dequeued vertex, and search-all
//  also steps through every start candidate. Synchronous active-low reset; no
//  clearing pass. A stalled result side fills a four-entry result queue, then
//  halts the engine; the two-entry command queue then fills and raises full.
// ----------------------------------------------------------------------------
module graph_bfs_order_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [gbfs_pkg::VCW-1:0] i_cfg_wdata,
    input  logic                     push,
    output logic                     full,
    input  gbfs_pkg::t_in            i_item,
    output logic                     empty,
    input  logic                     pop,
    output gbfs_pkg::t_out           o_res
);
    logic           cmd_valid, cmd_take, res_push, res_full;
    gbfs_pkg::t_cmd cmd;
    gbfs_pkg::t_out res;

    // accept and classify items
    gbfs_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .push, .full, .i_item,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    // carry out commands against the edge store
    gbfs_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .o_res_push(res_push), .o_res(res), .i_res_full(res_full)
    );

    // hold results until popped
    gbfs_res_fifo u_res (
        .i_clk, .i_rst_n,
        .i_push(res_push), .i_res(res), .o_full(res_full),
        .empty, .pop, .o_res
    );
endmodule

/* tb/graph_bfs_order_top_test.sv */
// ----------------------------------------------------------------------------
// graph_bfs_order_top_test - BFS engine testbench
// Drives edge loads and searches through the push/full side. Keeps a local
// model of the edge store that predicts each visit order, and compares every
// popped result against it. Item and pop gaps are random.
// ----------------------------------------------------------------------------
module graph_bfs_order_top_test;
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [gbfs_pkg::VCW-1:0]       i_cfg_wdata;
    logic                           push;
    logic                           full;
    gbfs_pkg::t_in                  i_item;
    logic                           empty;
    logic                           pop;
    gbfs_pkg::t_out                 o_res;

    graph_bfs_order_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res)
    );

    // Local copy of the graph state.
    logic [gbfs_pkg::VW-1:0]  graph_a [gbfs_pkg::MAX_EDGES];
    logic [gbfs_pkg::VW-1:0]  graph_b [gbfs_pkg::MAX_EDGES];
    int                       graph_edges = 0;
    logic [gbfs_pkg::VCW-1:0] vcount_reg;

    gbfs_pkg::t_in  pending_items[$];
    gbfs_pkg::t_out visit_expect[$];
    int   errors = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   searches_run = 0;
    bit   driver_quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("timeout at %0t", $time);
        $display("simulation failed");
        $finish;
    end

    function automatic int live_count();
        return (vcount_reg < gbfs_pkg::MAX_VERTICES) ? int'(vcount_reg)
                                                     : gbfs_pkg::MAX_VERTICES;
    endfunction

    function automatic gbfs_pkg::t_out make_res(logic [gbfs_pkg::VW-1:0] v, logic l,
                                                logic [1:0] st);
        gbfs_pkg::t_out r;
        r.vertex = v;
        r.last   = l;
        r.status = st;
        return r;
    endfunction

    // Walk one component from start, appending the visit order.
    task automatic walk_component(int start, int lim, ref bit seen[gbfs_pkg::MAX_VERTICES],
                                  ref gbfs_pkg::t_out order[$]);
        int bfs_q[$];
        int u;
        int nb;
        seen[start] = 1'b1;
        bfs_q = {bfs_q, start};
        while (bfs_q.size() > 0) begin
            u = bfs_q.pop_front();
            order = {order, make_res(gbfs_pkg::VW'(u), 1'b0, gbfs_pkg::ST_OK)};
            for (int e = 0; e < graph_edges; e++) begin
                if (graph_a[e] == u)      nb = graph_b[e];
                else if (graph_b[e] == u) nb = graph_a[e];
                else continue;
                if (nb >= lim || seen[nb]) continue;
                seen[nb] = 1'b1;
                bfs_q = {bfs_q, nb};
            end
        end
    endtask

    // Predict the results of one accepted item and update the graph.
    task automatic predict_visits(gbfs_pkg::t_in it);
        int   lim;
        bit   seen[gbfs_pkg::MAX_VERTICES];
        gbfs_pkg::t_out order[$];
        lim = live_count();
        foreach (seen[i]) seen[i] = 1'b0;
        case (it.mode)
            gbfs_pkg::MODE_CLEAR: begin
                graph_edges = 0;
                order = {order, make_res('0, 1'b1, gbfs_pkg::ST_OK)};
            end
            gbfs_pkg::MODE_ADD: begin
                if (it.vertex_a >= lim || it.vertex_b >= lim) begin
                    order = {order, make_res('0, 1'b1, gbfs_pkg::ST_RANGE)};
                end else if (graph_edges >= gbfs_pkg::MAX_EDGES) begin
                    order = {order, make_res('0, 1'b1, gbfs_pkg::ST_FULL)};
                end else begin
                    graph_a[graph_edges] = it.vertex_a;
                    graph_b[graph_edges] = it.vertex_b;
                    graph_edges++;
                    order = {order, make_res('0, 1'b1, gbfs_pkg::ST_OK)};
                end
            end
            gbfs_pkg::MODE_SEARCH: begin
                searches_run++;
                if (it.vertex_a >= lim)
                    order = {order, make_res('0, 1'b1, gbfs_pkg::ST_RANGE)};
                else walk_component(int'(it.vertex_a), lim, seen, order);
            end
            default: begin
                searches_run++;
                for (int s = 0; s < lim; s++)
                    if (!seen[s]) walk_component(s, lim, seen, order);
            end
        endcase
        if (order.size() > 0) order[order.size()-1].last = 1'b1;
        foreach (order[i]) visit_expect = {visit_expect, order[i]};
    endtask

    // Driver: feed queued items with random gaps, holding each item until accepted.
    int drv_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push    <= 1'b0;
            i_item  <= '0;
            drv_gap <= 0;
        end else begin
            if (push && !full) begin
                predict_visits(i_item);
                items_sent++;
            end
            if (push && full) begin
                // hold the item until taken
            end else if (drv_gap > 0 || driver_quiet || pending_items.size() == 0) begin
                push <= 1'b0;
                if (drv_gap > 0) drv_gap <= drv_gap - 1;
            end else begin
                i_item <= pending_items.pop_front();
                push   <= 1'b1;
                drv_gap <= ($urandom_range(0, 3) == 0)
                           ? (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                          : $urandom_range(1, 3)) : 0;
            end
        end
    end

    // Monitor: pop with random stalls and check each item taken.
    int pop_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop     <= 1'b0;
            pop_gap <= 0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (visit_expect.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, o_res);
                end else begin
                    gbfs_pkg::t_out want;
                    want = visit_expect.pop_front();
                    if (want.vertex !== o_res.vertex || want.last !== o_res.last ||
                        want.status !== o_res.status) begin
                        errors++;
                        $display("%0t: expected %p, got %p", $time, want, o_res);
                    end
                end
            end
            if (pop_gap > 0) begin
                pop     <= 1'b0;
                pop_gap <= pop_gap - 1;
            end else if ($urandom_range(0, 4) == 0) begin
                pop     <= 1'b0;
                pop_gap <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 2);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic gbfs_pkg::t_in mk_item(logic [1:0] m, int a, int b);
        gbfs_pkg::t_in it;
        it.mode = m;
        it.vertex_a = gbfs_pkg::VW'(a);
        it.vertex_b = gbfs_pkg::VW'(b);
        return it;
    endfunction

    // Queue one item for the driver.
    task automatic add_pending(gbfs_pkg::t_in it);
        pending_items = {pending_items, it};
    endtask

    // Wait for the block to drain, then write vertex_count.
    task automatic set_vertex_count(int n);
        while (pending_items.size() > 0 || push || visit_expect.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_wdata <= gbfs_pkg::VCW'(n);
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        vcount_reg  = gbfs_pkg::VCW'(n);
    endtask

    // Random graph: a few edges then searches; mostly small vertex counts.
    task automatic random_graph(int lim, int n_edges);
        add_pending(mk_item(gbfs_pkg::MODE_CLEAR, $urandom, $urandom));
        repeat (n_edges) begin
            if ($urandom_range(0, 9) == 0)
                add_pending(mk_item(gbfs_pkg::MODE_ADD, $urandom, $urandom));
            else
                add_pending(mk_item(gbfs_pkg::MODE_ADD, $urandom_range(0, lim - 1),
                                    $urandom_range(0, lim - 1)));
        end
        add_pending(mk_item(gbfs_pkg::MODE_SEARCH, $urandom_range(0, lim - 1),
                            $urandom));
        add_pending(mk_item(gbfs_pkg::MODE_ALL, $urandom, $urandom));
        if ($urandom_range(0, 3) == 0)
            add_pending(mk_item(gbfs_pkg::MODE_SEARCH, $urandom, $urandom));
    endtask

    initial begin
        int lim;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        driver_quiet = 1'b0;
        vcount_reg = gbfs_pkg::VCNT_MAX;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: defaults with 64 vertices, extremes, self loop, range errors.
        add_pending(mk_item(gbfs_pkg::MODE_ALL, 0, 0));
        add_pending(mk_item(gbfs_pkg::MODE_ADD, 0, 63));
        add_pending(mk_item(gbfs_pkg::MODE_ADD, 63, 5));
        add_pending(mk_item(gbfs_pkg::MODE_ADD, 5, 5));
        add_pending(mk_item(gbfs_pkg::MODE_ADD, 0, 1));
        add_pending(mk_item(gbfs_pkg::MODE_SEARCH, 0, 63));
        add_pending(mk_item(gbfs_pkg::MODE_SEARCH, 63, 0));
        set_vertex_count(4);
        add_pending(mk_item(gbfs_pkg::MODE_ADD, 4, 0));
        add_pending(mk_item(gbfs_pkg::MODE_ADD, 2, 63));
        add_pending(mk_item(gbfs_pkg::MODE_ADD, 2, 3));
        add_pending(mk_item(gbfs_pkg::MODE_SEARCH, 63, 0));
        add_pending(mk_item(gbfs_pkg::MODE_SEARCH, 0, 0));
        add_pending(mk_item(gbfs_pkg::MODE_ALL, 0, 0));
        set_vertex_count(0);
        add_pending(mk_item(gbfs_pkg::MODE_ALL, 0, 0));
        add_pending(mk_item(gbfs_pkg::MODE_SEARCH, 0, 0));
        add_pending(mk_item(gbfs_pkg::MODE_ADD, 0, 0));
        set_vertex_count(1);
        add_pending(mk_item(gbfs_pkg::MODE_ADD, 0, 0));
        add_pending(mk_item(gbfs_pkg::MODE_ALL, 0, 0));

        // Random phases with varied vertex counts.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: lim = $urandom_range(2, 8);
                1: lim = $urandom_range(9, 20);
                2: lim = 64;
                default: lim = $urandom_range(1, 64);
            endcase
            set_vertex_count((ph == 2) ? $urandom_range(64, 127) : lim);
            repeat (2) random_graph(lim, $urandom_range(2, 6));
        end

        while (pending_items.size() > 0 || push || visit_expect.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("sent %0d items, checked %0d results, %0d searches",
                 items_sent, results_seen, searches_run);
        if (errors == 0 && visit_expect.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
